// ===== rtl/core/ecpt_pkg.sv =====
package ecpt_pkg;

    localparam int COUNTER_SLOTS   = 4;
    localparam int POLL_SETS       = 2;
    localparam int WATCHES_PER_SET = 8;
    localparam int WATCHES         = POLL_SETS * WATCHES_PER_SET;
    localparam int CW = (COUNTER_SLOTS > 1) ? $clog2(COUNTER_SLOTS) : 1;
    localparam int SW = (POLL_SETS > 1) ? $clog2(POLL_SETS) : 1;
    localparam int WW = (WATCHES_PER_SET > 1) ? $clog2(WATCHES_PER_SET) : 1;
    localparam int KW = (WATCHES > 1) ? $clog2(WATCHES) : 1;
    localparam int OUT_MAX = 8;
    localparam int NW = $clog2(OUT_MAX + 1);

    localparam logic [10:0] COUNTER_BASE = 11'd1000;
    localparam logic [10:0] SET_BASE     = 11'd1100;

    localparam logic [3:0] CMD_CREATE = 4'd0;
    localparam logic [3:0] CMD_READ   = 4'd1;
    localparam logic [3:0] CMD_WRITE  = 4'd2;
    localparam logic [3:0] CMD_CLOSE  = 4'd3;
    localparam logic [3:0] CMD_PCREATE= 4'd4;
    localparam logic [3:0] CMD_ADD    = 4'd5;
    localparam logic [3:0] CMD_MOD    = 4'd6;
    localparam logic [3:0] CMD_DEL    = 4'd7;
    localparam logic [3:0] CMD_WAIT   = 4'd8;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_NOSLOT   = 3'd1;
    localparam logic [2:0] ST_INVALID  = 3'd2;
    localparam logic [2:0] ST_EXISTS   = 3'd3;
    localparam logic [2:0] ST_NOSPACE  = 3'd4;
    localparam logic [2:0] ST_NOTFOUND = 3'd5;
    localparam logic [2:0] ST_BLOCK    = 3'd6;
    localparam logic [2:0] ST_NOTLOCAL = 3'd7;

    typedef struct packed {
        logic [3:0]  cmd;
        logic [10:0] handle;
        logic [10:0] poll_handle;
        logic [63:0] value;
        logic        semaphore;
        logic [7:0]  byte_count;
        logic        event_present;
        logic [31:0] event_mask;
        logic [63:0] event_data;
        logic [7:0]  max_events;
    } in_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [63:0] ret_value;
        logic        event_valid;
        logic [63:0] ready_data;
        logic        last;
    } out_t;

    // controller -> datapath
    typedef struct packed {
        logic load;      // capture request, decode
        logic exec;      // apply single-result command
        logic scan_rd;   // issue watch read for scan index
        logic scan_chk;  // evaluate returned watch
        logic emit_rd;   // read found-list entry
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic       is_wait;   // request is a valid wait (events scan needed)
        logic       scan_done;
        logic [NW-1:0] found;
        logic       emit_last;
    } stat_t;

endpackage

// ===== rtl/core/ecpt_ram.sv =====
module ecpt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/core/ecpt_ctrl.sv =====
module ecpt_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    output logic            out_valid,
    input  logic            out_stall,
    output ecpt_pkg::cmd_t  cmd,
    input  ecpt_pkg::stat_t stat
);

    typedef enum logic [2:0] {IDLE, DEC, EXEC, SCAN, CHK, EMIT, OUT} state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg;
        cmd            = '0;
        case (state_reg)
            IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = DEC;
                end
            end
            DEC:
            begin
                state_next = stat.is_wait ? SCAN : EXEC;
            end
            EXEC:
            begin
                cmd.exec       = 1'b1;
                out_valid_next = 1'b1;
                state_next     = OUT;
            end
            SCAN:
            begin
                cmd.scan_rd = 1'b1;
                state_next  = CHK;
            end
            CHK:
            begin
                cmd.scan_chk = 1'b1;
                state_next   = stat.scan_done ? EXEC : SCAN;
                if (stat.scan_done)
                begin
                    state_next = (stat.found == '0) ? EXEC : EMIT;
                end
            end
            EMIT:
            begin
                cmd.emit_rd    = 1'b1;
                out_valid_next = 1'b1;
                state_next     = OUT;
            end
            OUT:
            begin
                if (!out_stall)
                begin
                    out_valid_next = 1'b0;
                    state_next     = stat.emit_last ? IDLE : EMIT;
                end
            end
            default:
            begin
                state_next = IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != IDLE);
    assign out_valid = out_valid_reg;

endmodule

// ===== rtl/core/ecpt_dp.sv =====
module ecpt_dp (
    input  logic            clk,
    input  logic            rst_n,
    input  ecpt_pkg::in_t   req,
    input  ecpt_pkg::cmd_t  cmd,
    output ecpt_pkg::stat_t stat,
    output ecpt_pkg::out_t  rsp
);

    localparam int CN  = ecpt_pkg::COUNTER_SLOTS;
    localparam int PN  = ecpt_pkg::POLL_SETS;
    localparam int WN  = ecpt_pkg::WATCHES_PER_SET;
    localparam int KN  = ecpt_pkg::WATCHES;
    localparam int CW  = ecpt_pkg::CW;
    localparam int SW  = ecpt_pkg::SW;
    localparam int WW  = ecpt_pkg::WW;
    localparam int KW  = ecpt_pkg::KW;
    localparam int NW  = ecpt_pkg::NW;
    localparam int OM  = ecpt_pkg::OUT_MAX;
    localparam int LW  = $clog2(OM);
    localparam int WDW = 11 + 32 + 64;

    ecpt_pkg::in_t r_reg;

    logic          cu_reg [CN];
    logic          cs_reg [CN];
    logic [63:0]   cv_reg [CN];
    logic          su_reg [PN];
    logic [KN-1:0] wu_reg;

    // decode results, registered at DEC
    logic          c_hit_reg, s_hit_reg, w_hit_reg, w_free_ok_reg;
    logic [CW-1:0] c_idx_reg;
    logic [SW-1:0] s_idx_reg;
    logic [WW-1:0] w_idx_reg, w_free_reg;
    logic          dec_reg;

    // scan
    logic [WW:0]   scan_reg;
    logic [WW-1:0] chk_reg;
    logic [NW-1:0] found_reg;
    logic [NW-1:0] emit_reg;
    logic [NW-1:0] limit;
    logic [63:0]   flist_reg [OM];

    ecpt_pkg::out_t rsp_reg;

    // lookup
    logic [10:0]   c_off, s_off, p_off;
    logic          c_hit, s_hit, p_hit;
    logic [CW-1:0] c_idx;
    logic [SW-1:0] s_idx, p_idx;

    always_comb
    begin
        c_off = r_reg.handle - ecpt_pkg::COUNTER_BASE;
        s_off = r_reg.handle - ecpt_pkg::SET_BASE;
        p_off = r_reg.poll_handle - ecpt_pkg::SET_BASE;
        c_idx = c_off[CW-1:0];
        s_idx = s_off[SW-1:0];
        p_idx = p_off[SW-1:0];
        c_hit = (r_reg.handle >= ecpt_pkg::COUNTER_BASE) && (c_off < 11'(CN)) && cu_reg[c_idx];
        s_hit = (r_reg.handle >= ecpt_pkg::SET_BASE) && (s_off < 11'(PN)) && su_reg[s_idx];
        p_hit = (r_reg.poll_handle >= ecpt_pkg::SET_BASE) && (p_off < 11'(PN))
                && su_reg[p_idx];
    end

    // watch RAM (handle, mask, data); validity in wu_reg
    logic          ram_we;
    logic [KW-1:0] ram_waddr, ram_raddr;
    logic [WDW-1:0] ram_wdata, ram_rdata;

    ecpt_ram #(.WIDTH(WDW), .DEPTH(KN)) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // watch handles kept in flops too, for a parallel match
    logic [10:0] wh_reg [KN];
    logic [WN-1:0] wmatch;
    logic          w_hit;
    logic [WW-1:0] w_idx, w_free;
    logic          w_free_ok;

    always_comb
    begin
        w_hit = 1'b0;
        w_idx = '0;
        w_free_ok = 1'b0;
        w_free = '0;
        for (int i = WN - 1; i >= 0; i--)
        begin
            wmatch[i] = wu_reg[{p_idx, WW'(i)}] && (wh_reg[{p_idx, WW'(i)}] == r_reg.handle);
            if (wmatch[i])
            begin
                w_hit = 1'b1;
                w_idx = WW'(i);
            end
            if (!wu_reg[{p_idx, WW'(i)}])
            begin
                w_free_ok = 1'b1;
                w_free = WW'(i);
            end
        end
    end

    // first free counter / set
    logic          c_free_ok, s_free_ok;
    logic [CW-1:0] c_free;
    logic [SW-1:0] s_free;

    always_comb
    begin
        c_free_ok = 1'b0;
        c_free = '0;
        for (int i = CN - 1; i >= 0; i--)
        begin
            if (!cu_reg[i])
            begin
                c_free_ok = 1'b1;
                c_free = CW'(i);
            end
        end
        s_free_ok = 1'b0;
        s_free = '0;
        for (int i = PN - 1; i >= 0; i--)
        begin
            if (!su_reg[i])
            begin
                s_free_ok = 1'b1;
                s_free = SW'(i);
            end
        end
    end

    assign limit = (r_reg.max_events < 8'(OM)) ? NW'(r_reg.max_events) : NW'(OM);

    // scan evaluation of returned watch
    logic [10:0]   wv_h;
    logic [31:0]   wv_m;
    logic [63:0]   wv_d;
    logic [10:0]   wv_off;
    logic [CW-1:0] wv_c;
    logic          wv_ready;

    always_comb
    begin
        {wv_h, wv_m, wv_d} = ram_rdata;
        wv_off = wv_h - ecpt_pkg::COUNTER_BASE;
        wv_c   = wv_off[CW-1:0];
        wv_ready = wu_reg[{s_idx_reg, chk_reg}] && (wv_h >= ecpt_pkg::COUNTER_BASE)
                   && (wv_off < 11'(CN)) && cu_reg[wv_c] && (cv_reg[wv_c] != 64'd0)
                   && wv_m[0];
    end

    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = {s_idx_reg, w_free_reg};
        ram_wdata = {r_reg.handle, r_reg.event_mask, r_reg.event_data};
        ram_raddr = {s_idx_reg, scan_reg[WW-1:0]};
        if (cmd.exec && s_hit_reg && r_reg.event_present)
        begin
            if (r_reg.cmd == ecpt_pkg::CMD_ADD && !w_hit_reg && w_free_ok_reg)
            begin
                ram_we = 1'b1;
            end
            else if (r_reg.cmd == ecpt_pkg::CMD_MOD && w_hit_reg)
            begin
                ram_we    = 1'b1;
                ram_waddr = {s_idx_reg, w_idx_reg};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            r_reg <= req;
        end
        if (ram_we)
        begin
            wh_reg[ram_waddr] <= r_reg.handle;
        end
        if (cmd.scan_chk && wv_ready && found_reg < limit)
        begin
            flist_reg[found_reg[LW-1:0]] <= wv_d;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CN; i++)
            begin
                cu_reg[i] <= 1'b0;
                cs_reg[i] <= 1'b0;
                cv_reg[i] <= 64'd0;
            end
            for (int i = 0; i < PN; i++)
            begin
                su_reg[i] <= 1'b0;
            end
            wu_reg        <= '0;
            dec_reg       <= 1'b0;
            c_hit_reg     <= 1'b0;
            s_hit_reg     <= 1'b0;
            w_hit_reg     <= 1'b0;
            w_free_ok_reg <= 1'b0;
            c_idx_reg     <= '0;
            s_idx_reg     <= '0;
            w_idx_reg     <= '0;
            w_free_reg    <= '0;
            scan_reg      <= '0;
            chk_reg       <= '0;
            found_reg     <= '0;
            emit_reg      <= '0;
            rsp_reg       <= '0;
        end
        else
        begin
            dec_reg <= 1'b0;
            if (cmd.load)
            begin
                dec_reg   <= 1'b1;
                scan_reg  <= '0;
                found_reg <= '0;
                emit_reg  <= '0;
            end
            if (dec_reg)
            begin
                c_hit_reg     <= c_hit;
                c_idx_reg     <= c_idx;
                s_hit_reg     <= (r_reg.cmd == ecpt_pkg::CMD_CLOSE) ? s_hit : p_hit;
                s_idx_reg     <= (r_reg.cmd == ecpt_pkg::CMD_CLOSE) ? s_idx : p_idx;
                w_hit_reg     <= w_hit;
                w_idx_reg     <= w_idx;
                w_free_ok_reg <= w_free_ok;
                w_free_reg    <= w_free;
            end
            if (cmd.scan_rd)
            begin
                chk_reg  <= scan_reg[WW-1:0];
                scan_reg <= scan_reg + 1'b1;
            end
            if (cmd.scan_chk && wv_ready && found_reg < limit)
            begin
                found_reg <= found_reg + 1'b1;
            end
            if (cmd.emit_rd)
            begin
                rsp_reg.status      <= ecpt_pkg::ST_OK;
                rsp_reg.ret_value   <= 64'(found_reg);
                rsp_reg.event_valid <= 1'b1;
                rsp_reg.ready_data  <= flist_reg[emit_reg[LW-1:0]];
                rsp_reg.last        <= (emit_reg + 1'b1 == found_reg);
                emit_reg            <= emit_reg + 1'b1;
            end
            if (cmd.exec)
            begin
                rsp_reg.status      <= ecpt_pkg::ST_OK;
                rsp_reg.ret_value   <= 64'd0;
                rsp_reg.event_valid <= 1'b0;
                rsp_reg.ready_data  <= 64'd0;
                rsp_reg.last        <= 1'b1;
                emit_reg            <= found_reg;
                case (r_reg.cmd)
                    ecpt_pkg::CMD_CREATE:
                    begin
                        if (c_free_ok)
                        begin
                            cu_reg[c_free] <= 1'b1;
                            cs_reg[c_free] <= r_reg.semaphore;
                            cv_reg[c_free] <= {32'd0, r_reg.value[31:0]};
                            rsp_reg.ret_value <= 64'(ecpt_pkg::COUNTER_BASE + 11'(c_free));
                        end
                        else
                        begin
                            rsp_reg.status <= ecpt_pkg::ST_NOSLOT;
                        end
                    end
                    ecpt_pkg::CMD_READ:
                    begin
                        if (!c_hit_reg)
                            rsp_reg.status <= ecpt_pkg::ST_NOTLOCAL;
                        else if (r_reg.byte_count < 8'd8)
                            rsp_reg.status <= ecpt_pkg::ST_INVALID;
                        else if (cv_reg[c_idx_reg] == 64'd0)
                            rsp_reg.status <= ecpt_pkg::ST_BLOCK;
                        else if (cs_reg[c_idx_reg])
                        begin
                            cv_reg[c_idx_reg] <= cv_reg[c_idx_reg] - 64'd1;
                            rsp_reg.ret_value <= 64'd1;
                        end
                        else
                        begin
                            cv_reg[c_idx_reg] <= 64'd0;
                            rsp_reg.ret_value <= cv_reg[c_idx_reg];
                        end
                    end
                    ecpt_pkg::CMD_WRITE:
                    begin
                        if (!c_hit_reg)
                            rsp_reg.status <= ecpt_pkg::ST_NOTLOCAL;
                        else if (r_reg.byte_count < 8'd8)
                            rsp_reg.status <= ecpt_pkg::ST_INVALID;
                        else
                        begin
                            cv_reg[c_idx_reg] <= cv_reg[c_idx_reg] + r_reg.value;
                            rsp_reg.ret_value <= 64'd8;
                        end
                    end
                    ecpt_pkg::CMD_CLOSE:
                    begin
                        if (c_hit_reg)
                        begin
                            cu_reg[c_idx_reg] <= 1'b0;
                            cs_reg[c_idx_reg] <= 1'b0;
                            cv_reg[c_idx_reg] <= 64'd0;
                        end
                        else if (s_hit_reg)
                        begin
                            su_reg[s_idx_reg] <= 1'b0;
                            for (int i = 0; i < WN; i++)
                                wu_reg[{s_idx_reg, WW'(i)}] <= 1'b0;
                        end
                        else
                            rsp_reg.status <= ecpt_pkg::ST_NOTLOCAL;
                    end
                    ecpt_pkg::CMD_PCREATE:
                    begin
                        if (s_free_ok)
                        begin
                            su_reg[s_free] <= 1'b1;
                            for (int i = 0; i < WN; i++)
                                wu_reg[{s_free, WW'(i)}] <= 1'b0;
                            rsp_reg.ret_value <= 64'(ecpt_pkg::SET_BASE + 11'(s_free));
                        end
                        else
                            rsp_reg.status <= ecpt_pkg::ST_NOSLOT;
                    end
                    ecpt_pkg::CMD_ADD, ecpt_pkg::CMD_MOD, ecpt_pkg::CMD_DEL:
                    begin
                        if (!s_hit_reg)
                            rsp_reg.status <= ecpt_pkg::ST_NOTLOCAL;
                        else if (r_reg.cmd != ecpt_pkg::CMD_DEL && !r_reg.event_present)
                            rsp_reg.status <= ecpt_pkg::ST_INVALID;
                        else if (r_reg.cmd == ecpt_pkg::CMD_ADD)
                        begin
                            if (w_hit_reg)
                                rsp_reg.status <= ecpt_pkg::ST_EXISTS;
                            else if (w_free_ok_reg)
                                wu_reg[{s_idx_reg, w_free_reg}] <= 1'b1;
                            else
                                rsp_reg.status <= ecpt_pkg::ST_NOSPACE;
                        end
                        else if (!w_hit_reg)
                            rsp_reg.status <= ecpt_pkg::ST_NOTFOUND;
                        else if (r_reg.cmd == ecpt_pkg::CMD_DEL)
                            wu_reg[{s_idx_reg, w_idx_reg}] <= 1'b0;
                    end
                    ecpt_pkg::CMD_WAIT:
                    begin
                        if (!s_hit_reg)
                            rsp_reg.status <= ecpt_pkg::ST_NOTLOCAL;
                        else if (r_reg.max_events == 8'd0)
                            rsp_reg.status <= ecpt_pkg::ST_INVALID;
                    end
                    default:
                    begin
                        rsp_reg.status <= ecpt_pkg::ST_INVALID;
                    end
                endcase
            end
        end
    end

    assign stat.is_wait   = dec_reg && (r_reg.cmd == ecpt_pkg::CMD_WAIT) && p_hit
                            && (r_reg.max_events != 8'd0);
    assign stat.scan_done = (scan_reg == (WW + 1)'(WN)) || (found_reg == limit)
                            || (wv_ready && (found_reg + 1'b1 == limit));
    assign stat.found     = (cmd.scan_chk && wv_ready && found_reg < limit)
                            ? found_reg + 1'b1 : found_reg;
    assign stat.emit_last = (emit_reg == found_reg);
    assign rsp = rsp_reg;

endmodule

// ===== rtl/core/event_counter_poll_table_unit.sv =====
// Event counter and poll set table. One request transaction is taken at a time;
// in_stall stays high until every result of it has been delivered. Single-result
// requests and every result of a wait are held while out_stall is high; a wait scans
// its poll set's watches through the watch RAM one watch at a time, stopping early at
// the event limit, and then emits one result per ready event, or a single result
// when no event is ready.
module event_counter_poll_table_unit (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    input  ecpt_pkg::in_t   in_data,
    output logic            out_valid,
    input  logic            out_stall,
    output ecpt_pkg::out_t  out_data
);

    ecpt_pkg::cmd_t  cmd;
    ecpt_pkg::stat_t stat;

    ecpt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .cmd       (cmd),
        .stat      (stat)
    );

    ecpt_dp u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (in_data),
        .cmd   (cmd),
        .stat  (stat),
        .rsp   (out_data)
    );

endmodule

// ===== test/event_counter_poll_table_unit_tb.sv =====
module event_counter_poll_table_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ecpt_pkg::*;

    localparam int CYCLE_LIMIT = 200000;

    class ecpt_scoreboard;
        bit        cnt_used[COUNTER_SLOTS];
        bit        cnt_sem[COUNTER_SLOTS];
        bit [63:0] cnt_val[COUNTER_SLOTS];
        bit        set_live[POLL_SETS];
        bit        w_used[WATCHES];
        bit [10:0] w_handle[WATCHES];
        bit [31:0] w_mask[WATCHES];
        bit [63:0] w_data[WATCHES];
        out_t      pending[$];
        int        errors;

        function int counter_slot(bit [10:0] h);
            if (h >= COUNTER_BASE && h < COUNTER_BASE + COUNTER_SLOTS)
                if (cnt_used[h - COUNTER_BASE])
                    return h - COUNTER_BASE;
            return -1;
        endfunction

        function int set_slot(bit [10:0] h);
            if (h >= SET_BASE && h < SET_BASE + POLL_SETS)
                if (set_live[h - SET_BASE])
                    return h - SET_BASE;
            return -1;
        endfunction

        function int watch_slot(int s, bit [10:0] h);
            for (int w = 0; w < WATCHES_PER_SET; w++)
                if (w_used[s * WATCHES_PER_SET + w] && w_handle[s * WATCHES_PER_SET + w] == h)
                    return s * WATCHES_PER_SET + w;
            return -1;
        endfunction

        function void push_one(logic [2:0] st, logic [63:0] rv);
            out_t r;
            r = '0;
            r.status = st;
            r.ret_value = rv;
            r.last = 1'b1;
            pending.push_back(r);
        endfunction

        function void note_request(in_t t);
            int c;
            int s;
            int k;
            int lim;
            int free_w;
            bit [63:0] found[$];
            out_t r;
            case (t.cmd)
                CMD_CREATE:
                begin
                    c = -1;
                    for (int i = COUNTER_SLOTS - 1; i >= 0; i--)
                        if (!cnt_used[i])
                            c = i;
                    if (c < 0)
                        push_one(ST_NOSLOT, 0);
                    else
                    begin
                        cnt_used[c] = 1;
                        cnt_sem[c] = t.semaphore;
                        cnt_val[c] = {32'd0, t.value[31:0]};
                        push_one(ST_OK, 64'(COUNTER_BASE + c));
                    end
                end
                CMD_READ, CMD_WRITE:
                begin
                    c = counter_slot(t.handle);
                    if (c < 0)
                        push_one(ST_NOTLOCAL, 0);
                    else if (t.byte_count < 8)
                        push_one(ST_INVALID, 0);
                    else if (t.cmd == CMD_WRITE)
                    begin
                        cnt_val[c] += t.value;
                        push_one(ST_OK, 8);
                    end
                    else if (cnt_val[c] == 0)
                        push_one(ST_BLOCK, 0);
                    else if (cnt_sem[c])
                    begin
                        cnt_val[c] -= 1;
                        push_one(ST_OK, 1);
                    end
                    else
                    begin
                        push_one(ST_OK, cnt_val[c]);
                        cnt_val[c] = 0;
                    end
                end
                CMD_CLOSE:
                begin
                    c = counter_slot(t.handle);
                    s = set_slot(t.handle);
                    if (c >= 0)
                    begin
                        cnt_used[c] = 0;
                        cnt_sem[c] = 0;
                        cnt_val[c] = 0;
                        push_one(ST_OK, 0);
                    end
                    else if (s >= 0)
                    begin
                        set_live[s] = 0;
                        for (int w = 0; w < WATCHES_PER_SET; w++)
                            w_used[s * WATCHES_PER_SET + w] = 0;
                        push_one(ST_OK, 0);
                    end
                    else
                        push_one(ST_NOTLOCAL, 0);
                end
                CMD_PCREATE:
                begin
                    s = -1;
                    for (int i = POLL_SETS - 1; i >= 0; i--)
                        if (!set_live[i])
                            s = i;
                    if (s < 0)
                        push_one(ST_NOSLOT, 0);
                    else
                    begin
                        set_live[s] = 1;
                        for (int w = 0; w < WATCHES_PER_SET; w++)
                            w_used[s * WATCHES_PER_SET + w] = 0;
                        push_one(ST_OK, 64'(SET_BASE + s));
                    end
                end
                CMD_ADD, CMD_MOD, CMD_DEL:
                begin
                    s = set_slot(t.poll_handle);
                    if (s < 0)
                        push_one(ST_NOTLOCAL, 0);
                    else if (t.cmd != CMD_DEL && !t.event_present)
                        push_one(ST_INVALID, 0);
                    else
                    begin
                        k = watch_slot(s, t.handle);
                        if (t.cmd == CMD_ADD)
                        begin
                            free_w = -1;
                            for (int w = WATCHES_PER_SET - 1; w >= 0; w--)
                                if (!w_used[s * WATCHES_PER_SET + w])
                                    free_w = s * WATCHES_PER_SET + w;
                            if (k >= 0)
                                push_one(ST_EXISTS, 0);
                            else if (free_w < 0)
                                push_one(ST_NOSPACE, 0);
                            else
                            begin
                                w_used[free_w] = 1;
                                w_handle[free_w] = t.handle;
                                w_mask[free_w] = t.event_mask;
                                w_data[free_w] = t.event_data;
                                push_one(ST_OK, 0);
                            end
                        end
                        else if (k < 0)
                            push_one(ST_NOTFOUND, 0);
                        else
                        begin
                            if (t.cmd == CMD_MOD)
                            begin
                                w_mask[k] = t.event_mask;
                                w_data[k] = t.event_data;
                            end
                            else
                                w_used[k] = 0;
                            push_one(ST_OK, 0);
                        end
                    end
                end
                CMD_WAIT:
                begin
                    s = set_slot(t.poll_handle);
                    if (s < 0)
                        push_one(ST_NOTLOCAL, 0);
                    else if (t.max_events == 0)
                        push_one(ST_INVALID, 0);
                    else
                    begin
                        lim = (t.max_events < OUT_MAX) ? t.max_events : OUT_MAX;
                        for (int w = 0; w < WATCHES_PER_SET; w++)
                        begin
                            k = s * WATCHES_PER_SET + w;
                            if (found.size() < lim && w_used[k])
                            begin
                                c = counter_slot(w_handle[k]);
                                if (c >= 0 && cnt_val[c] != 0 && w_mask[k][0])
                                    found.push_back(w_data[k]);
                            end
                        end
                        if (found.size() == 0)
                            push_one(ST_OK, 0);
                        foreach (found[i])
                        begin
                            r.status = ST_OK;
                            r.ret_value = 64'(found.size());
                            r.event_valid = 1'b1;
                            r.ready_data = found[i];
                            r.last = (i == found.size() - 1);
                            pending.push_back(r);
                        end
                    end
                end
                default:
                    push_one(ST_INVALID, 0);
            endcase
        endfunction

        function void check_result(out_t got);
            out_t e;
            if (pending.size() == 0)
            begin
                $error("unexpected result transaction status=%0d", got.status);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (got.status !== e.status)
            begin
                $error("status expected %0d actual %0d", e.status, got.status);
                errors++;
            end
            if (got.ret_value !== e.ret_value)
            begin
                $error("ret_value expected %0h actual %0h", e.ret_value, got.ret_value);
                errors++;
            end
            if (got.event_valid !== e.event_valid)
            begin
                $error("event_valid expected %0b actual %0b", e.event_valid, got.event_valid);
                errors++;
            end
            if (got.ready_data !== e.ready_data)
            begin
                $error("ready_data expected %0h actual %0h", e.ready_data, got.ready_data);
                errors++;
            end
            if (got.last !== e.last)
            begin
                $error("last expected %0b actual %0b", e.last, got.last);
                errors++;
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    in_t  in_data = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    out_t out_data;

    ecpt_scoreboard sb = new();
    in_t  requests[$];
    int   sent = 0;
    bit   quiet = 0;
    bit   hold_req = 0;
    int   hold_cnt = 0;
    int   cycles = 0;

    event_counter_poll_table_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // receiver: check, then pick next stall
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            sb.check_result(out_data);
        if (hold_req && hold_cnt == 0)
        begin
            hold_req = 0;
            hold_cnt = 400;
        end
        if (hold_cnt > 0)
        begin
            hold_cnt--;
            out_stall <= 1'b1;
        end
        else
            out_stall <= !quiet && ($urandom_range(99) < 36);
    end

    function automatic in_t random_request();
        in_t t;
        int  p;
        t.value = {$urandom, $urandom};
        t.event_data = {$urandom, $urandom};
        t.event_mask = $urandom;
        t.semaphore = 1'($urandom_range(1));
        t.byte_count = ($urandom_range(9) == 0) ? 8'($urandom_range(7))
                                                : 8'($urandom_range(8, 255));
        t.event_present = ($urandom_range(9) != 0);
        t.max_events = ($urandom_range(4) == 0) ? 8'($urandom_range(255))
                                                : 8'($urandom_range(1, 8));
        t.poll_handle = ($urandom_range(7) == 0) ? 11'($urandom_range(2047))
                                                 : 11'(SET_BASE + $urandom_range(POLL_SETS - 1));
        t.handle = ($urandom_range(7) == 0) ? 11'($urandom_range(2047))
                                            : 11'(COUNTER_BASE
                                                  + $urandom_range(COUNTER_SLOTS - 1));
        if ($urandom_range(3) != 0)
            t.event_mask[0] = 1'b1;
        p = $urandom_range(99);
        if (p < 12)
            t.cmd = CMD_CREATE;
        else if (p < 27)
            t.cmd = CMD_READ;
        else if (p < 45)
            t.cmd = CMD_WRITE;
        else if (p < 51)
            t.cmd = CMD_CLOSE;
        else if (p < 56)
            t.cmd = CMD_PCREATE;
        else if (p < 70)
            t.cmd = CMD_ADD;
        else if (p < 77)
            t.cmd = CMD_MOD;
        else if (p < 82)
            t.cmd = CMD_DEL;
        else if (p < 97)
            t.cmd = CMD_WAIT;
        else
            t.cmd = 4'($urandom_range(9, 15));
        if (t.cmd == CMD_CLOSE && $urandom_range(2) == 0)
            t.handle = 11'(SET_BASE + $urandom_range(POLL_SETS - 1));
        if (t.cmd == CMD_ADD && $urandom_range(2) == 0)
            t.handle = 11'($urandom_range(2047));
        if (t.cmd == CMD_CREATE && $urandom_range(1))
            t.value = {32'd0, $urandom_range(3)};
        return t;
    endfunction

    function automatic in_t req(logic [3:0] cmd, logic [10:0] h, logic [10:0] ph);
        in_t t;
        t = random_request();
        t.cmd = cmd;
        t.handle = h;
        t.poll_handle = ph;
        t.byte_count = 8'd8;
        t.event_present = 1'b1;
        t.max_events = 8'd8;
        return t;
    endfunction

    task automatic build_directed();
        in_t t;
        t = req(CMD_CREATE, 0, 0); t.value = '1; t.semaphore = 0; requests.push_back(t);
        t = req(CMD_CREATE, 0, 0); t.value = 64'd3; t.semaphore = 1; requests.push_back(t);
        t = req(CMD_CREATE, 0, 0); t.value = 64'd0; requests.push_back(t);
        t = req(CMD_CREATE, 0, 0); t.value = 64'hFFFF_FFFF_0000_0000; requests.push_back(t);
        t = req(CMD_CREATE, 0, 0); requests.push_back(t);
        requests.push_back(req(CMD_PCREATE, 0, 0));
        requests.push_back(req(CMD_PCREATE, 0, 0));
        requests.push_back(req(CMD_PCREATE, 0, 0));
        t = req(CMD_ADD, 11'd1000, 11'd1100); t.event_mask = 32'hFFFF_FFFF;
        t.event_data = '1; requests.push_back(t);
        t = req(CMD_ADD, 11'd1001, 11'd1100); t.event_mask = 32'd1; requests.push_back(t);
        requests.push_back(req(CMD_ADD, 11'd1000, 11'd1100));
        t = req(CMD_ADD, 11'd1002, 11'd1100); t.event_present = 0; requests.push_back(t);
        requests.push_back(req(CMD_MOD, 11'd1003, 11'd1100));
        t = req(CMD_MOD, 11'd1001, 11'd1100); t.event_mask = 32'hFFFF_FFFE; requests.push_back(t);
        requests.push_back(req(CMD_DEL, 11'd1002, 11'd1100));
        t = req(CMD_WRITE, 11'd1002, 0); t.byte_count = 8'd7; requests.push_back(t);
        t = req(CMD_WRITE, 11'd1002, 0); t.value = '1; t.byte_count = 8'd255; requests.push_back(t);
        requests.push_back(req(CMD_READ, 11'd1003, 0));
        requests.push_back(req(CMD_READ, 11'd1001, 0));
        t = req(CMD_WAIT, 0, 11'd1100); t.max_events = 0; requests.push_back(t);
        t = req(CMD_WAIT, 0, 11'd1100); t.max_events = 8'd255; requests.push_back(t);
        requests.push_back(req(CMD_WAIT, 0, 11'd2047));
        requests.push_back(req(CMD_READ, 11'd2047, 0));
        requests.push_back(req(4'd15, 0, 0));
        requests.push_back(req(CMD_CLOSE, 11'd1101, 0));
        requests.push_back(req(CMD_CLOSE, 11'd1000, 0));
    endtask

    task automatic send_all();
        in_t t;
        while (requests.size() != 0)
        begin
            t = requests.pop_front();
            quiet = (sent >= 50 && sent < 75);
            if (sent == 35)
                hold_req = 1;
            while (!quiet && $urandom_range(99) < 36)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
            in_valid <= 1'b1;
            in_data <= t;
            @(posedge clk);
            while (in_stall)
                @(posedge clk);
            sb.note_request(t);
            sent++;
        end
        in_valid <= 1'b0;
    endtask

    initial
    begin
        build_directed();
        for (int i = 0; i < 74; i++)
            requests.push_back(random_request());
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        send_all();
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
        if (sb.errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
